@@ hw/rtl/lcdser_pkg.sv @@
// types, codes and sequence tables of the character-lcd expander command serializer
`default_nettype none

package lcdser_pkg;

  localparam int unsigned IdxW = 6;

  typedef enum logic [3:0] {
    ACT_INIT      = 4'd0,
    ACT_WRITE     = 4'd1,
    ACT_CLEAR     = 4'd2,
    ACT_HOME      = 4'd3,
    ACT_CURSOR    = 4'd4,
    ACT_FLAG      = 4'd5,
    ACT_SCROLL    = 4'd6,
    ACT_BACKLIGHT = 4'd7,
    ACT_GLYPH     = 4'd8
  } action_t;

  typedef enum logic [2:0] {
    FLG_DISPLAY   = 3'd0,
    FLG_CURSOR    = 3'd1,
    FLG_BLINK     = 3'd2,
    FLG_INCREMENT = 3'd3,
    FLG_AUTOSCROLL = 3'd4
  } flag_sel_t;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR  = 2'd0,
    CFG_COLUMNS   = 2'd1,
    CFG_LINES     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_INIT = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_PIN  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    WAIT_NONE  = 3'd0,
    WAIT_POWER = 3'd1,
    WAIT_RST1  = 3'd2,
    WAIT_RST2  = 3'd3,
    WAIT_CLEAR = 3'd4
  } wait_code_t;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_ENTRY      = 8'h04;
  localparam logic [7:0] CMD_DISPLAY    = 8'h08;
  localparam logic [7:0] CMD_SCROLL_L   = 8'h18;
  localparam logic [7:0] CMD_SCROLL_R   = 8'h1C;
  localparam logic [7:0] CMD_GLYPH_ADDR = 8'h40;
  localparam logic [7:0] CMD_DDRAM_ADDR = 8'h80;
  localparam logic [7:0] ROW_ODD_OFFSET = 8'h40;
  localparam logic [6:0] MAX_COLUMNS    = 7'd80;
  localparam logic [2:0] MAX_LINES      = 3'd4;
  localparam logic [2:0] DISP_RESET     = 3'd4;
  localparam logic [1:0] ENTRY_RESET    = 2'd2;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] char_code;
    logic [7:0] column;
    logic [7:0] row;
    logic [2:0] flag_select;
    logic       flag_on;
    logic       direction;
    logic [7:0] brightness;
    logic [2:0] glyph_slot;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  bus_byte;
    logic        starts_transfer;
    logic        ends_transfer;
    logic [15:0] wait_us;
    logic        last_of_run;
  } out_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       rs;
    wait_code_t wcode;
    logic       bl;
  } desc_t;

  typedef struct packed {
    logic       has_bytes;
    desc_t      desc;
    logic [2:0] disp_nxt;
    logic [1:0] entry_nxt;
    logic       bl_nxt;
  } dec_t;

  typedef struct packed {
    logic       is_addr;
    logic [3:0] nib;
    logic       en;
    logic       fs_low;
    logic       ends;
    wait_code_t wcode;
  } init_entry_t;

  function automatic logic [15:0] wait_value(input wait_code_t w);
    logic [15:0] v;
    unique case (w)
      WAIT_POWER: v = 16'd50000;
      WAIT_RST1:  v = 16'd4500;
      WAIT_RST2:  v = 16'd200;
      WAIT_CLEAR: v = 16'd1600;
      default:    v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [IdxW-1:0] last_index(input kind_t k);
    logic [IdxW-1:0] v;
    unique case (k)
      KIND_INIT: v = IdxW'(33);
      KIND_BYTE: v = IdxW'(4);
      default:   v = IdxW'(1);
    endcase
    return v;
  endfunction

  // fields: is_addr, nib, en, fs_low, ends, wcode
  function automatic init_entry_t init_entry(input logic [IdxW-1:0] idx);
    init_entry_t e;
    unique case (idx)
      6'd0:  e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd1:  e = '{1'b0, 4'h0, 1'b0, 1'b0, 1'b1, WAIT_POWER};
      6'd2:  e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd3:  e = '{1'b0, 4'h3, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd4:  e = '{1'b0, 4'h3, 1'b0, 1'b0, 1'b1, WAIT_RST1};
      6'd5:  e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd6:  e = '{1'b0, 4'h3, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd7:  e = '{1'b0, 4'h3, 1'b0, 1'b0, 1'b1, WAIT_RST2};
      6'd8:  e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd9:  e = '{1'b0, 4'h3, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd10: e = '{1'b0, 4'h3, 1'b0, 1'b0, 1'b1, WAIT_RST2};
      6'd11: e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd12: e = '{1'b0, 4'h2, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd13: e = '{1'b0, 4'h2, 1'b0, 1'b0, 1'b1, WAIT_NONE};
      6'd14: e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd15: e = '{1'b0, 4'h2, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd16: e = '{1'b0, 4'h2, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd17: e = '{1'b0, 4'h0, 1'b1, 1'b1, 1'b0, WAIT_NONE};
      6'd18: e = '{1'b0, 4'h0, 1'b0, 1'b1, 1'b1, WAIT_NONE};
      6'd19: e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd20: e = '{1'b0, 4'h0, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd21: e = '{1'b0, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd22: e = '{1'b0, 4'hC, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd23: e = '{1'b0, 4'hC, 1'b0, 1'b0, 1'b1, WAIT_NONE};
      6'd24: e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd25: e = '{1'b0, 4'h0, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd26: e = '{1'b0, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd27: e = '{1'b0, 4'h1, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd28: e = '{1'b0, 4'h1, 1'b0, 1'b0, 1'b1, WAIT_CLEAR};
      6'd29: e = '{1'b1, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd30: e = '{1'b0, 4'h0, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd31: e = '{1'b0, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
      6'd32: e = '{1'b0, 4'h6, 1'b1, 1'b0, 1'b0, WAIT_NONE};
      6'd33: e = '{1'b0, 4'h6, 1'b0, 1'b0, 1'b1, WAIT_NONE};
      default: e = '{1'b0, 4'h0, 1'b0, 1'b0, 1'b0, WAIT_NONE};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/char_lcd_expander_command_serializer.sv @@
// top level of the character-lcd expander command serializer
//
// in_valid/in_stall/in_word take one lcd command per word; out_valid/out_stall/out_word
// give the bus bytes it causes, one per cycle while out_stall is low, each marked with
// start, stop, wait after the stop and the last byte of the command.
// cfg_we/cfg_index/cfg_wdata write device address, column count and line count;
// write them only while no command is in flight.
// the first byte of a command goes from the held command and index registers through
// the output register. throughput: init gives 34 bytes, backlight 2, every other
// command 5, at one byte per cycle while out_stall is low, set by the byte index
// counter walking the held command; the next command is accepted in the cycle its
// last byte is loaded into the output register, so commands follow back to back.
// flag writes with no valid selection and unknown actions give no bytes.
// reset restores address 39, 16 columns, 2 lines, display on, increment, backlight off.
// while out_stall is high the output word holds, the byte counter waits, and in_stall
// rises once the held command still has bytes to send.
`default_nettype none

module char_lcd_expander_command_serializer
  import lcdser_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata
);

  logic [6:0]      dev_addr_r, dev_addr_nxt;
  logic [6:0]      cols_r, cols_nxt;
  logic [2:0]      lines_r, lines_nxt;
  logic [2:0]      disp_r, disp_nxt;
  logic [1:0]      entry_r, entry_nxt;
  logic            bl_r, bl_nxt;
  logic            busy_r, busy_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  desc_t           desc_r, desc_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_word_r, out_word_nxt;

  dec_t            dec;
  out_word_t       gen_word;
  logic            out_load;
  logic            at_last;
  logic            in_acc;

  lcdser_decode u_decode (
    .cmd          (in_word),
    .column_count (cols_r),
    .line_count   (lines_r),
    .disp_cur     (disp_r),
    .entry_cur    (entry_r),
    .bl_cur       (bl_r),
    .dec          (dec)
  );

  lcdser_gen u_gen (
    .desc           (desc_r),
    .idx            (idx_r),
    .device_address (dev_addr_r),
    .line_count     (lines_r),
    .word           (gen_word)
  );

  assign out_load = busy_r && (!out_valid_r || !out_stall);
  assign at_last  = idx_r == last_index(desc_r.kind);
  assign in_stall = busy_r && !(out_load && at_last);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    cols_nxt     = cols_r;
    lines_nxt    = lines_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEV_ADDR: dev_addr_nxt = cfg_wdata;
        CFG_COLUMNS:  cols_nxt     = cfg_wdata;
        CFG_LINES:    lines_nxt    = cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    disp_nxt  = disp_r;
    entry_nxt = entry_r;
    bl_nxt    = bl_r;
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    desc_nxt  = desc_r;
    if (out_load) begin
      idx_nxt = idx_r + IdxW'(1);
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
    if (in_acc) begin
      disp_nxt  = dec.disp_nxt;
      entry_nxt = dec.entry_nxt;
      bl_nxt    = dec.bl_nxt;
      busy_nxt  = dec.has_bytes;
      idx_nxt   = '0;
      desc_nxt  = dec.desc;
    end
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_word_nxt  = out_load ? gen_word : out_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= 7'd39;
      cols_r      <= 7'd16;
      lines_r     <= 3'd2;
      disp_r      <= DISP_RESET;
      entry_r     <= ENTRY_RESET;
      bl_r        <= 1'b0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      dev_addr_r  <= dev_addr_nxt;
      cols_r      <= cols_nxt;
      lines_r     <= lines_nxt;
      disp_r      <= disp_nxt;
      entry_r     <= entry_nxt;
      bl_r        <= bl_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    desc_r     <= desc_nxt;
    out_word_r <= out_word_nxt;
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= last_index(desc_r.kind))
    else $error("byte index beyond end of command");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && at_last && !in_acc |=> !busy_r)
    else $error("sequencer still busy after last byte");

  a_addr_starts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.starts_transfer |->
      !out_word_r.ends_transfer && out_word_r.bus_byte == {dev_addr_r, 1'b0})
    else $error("start byte is not the address byte");

  a_wait_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_word_r.ends_transfer |-> out_word_r.wait_us == 16'd0)
    else $error("wait on a byte that does not end a transfer");

  a_last_is_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_word_r.last_of_run |-> out_word_r.ends_transfer)
    else $error("last byte of a command without stop");

endmodule

`default_nettype wire

@@ hw/rtl/lcdser_decode.sv @@
// command decode: controller byte, sequence kind and next flag state for one word
`default_nettype none

module lcdser_decode
  import lcdser_pkg::*;
(
  input  in_word_t   cmd,
  input  logic [6:0] column_count,
  input  logic [2:0] line_count,
  input  logic [2:0] disp_cur,
  input  logic [1:0] entry_cur,
  input  logic       bl_cur,
  output dec_t       dec
);

  logic [2:0] lines_eff;
  logic [6:0] cols_eff;
  logic [1:0] row_cl;
  logic [6:0] col_cl;
  logic [7:0] row_off;
  logic [7:0] addr_sum;
  logic [2:0] disp_mask;
  logic [1:0] entry_mask;

  always_comb begin
    if (line_count == 3'd0) begin
      lines_eff = 3'd1;
    end else if (line_count > MAX_LINES) begin
      lines_eff = MAX_LINES;
    end else begin
      lines_eff = line_count;
    end
    if (column_count == 7'd0) begin
      cols_eff = 7'd1;
    end else if (column_count > MAX_COLUMNS) begin
      cols_eff = MAX_COLUMNS;
    end else begin
      cols_eff = column_count;
    end
    if (cmd.row >= {5'd0, lines_eff}) begin
      row_cl = 2'(lines_eff - 3'd1);
    end else begin
      row_cl = cmd.row[1:0];
    end
    if (cmd.column >= {1'b0, cols_eff}) begin
      col_cl = cols_eff - 7'd1;
    end else begin
      col_cl = cmd.column[6:0];
    end
    row_off = (row_cl[0] ? ROW_ODD_OFFSET : 8'd0) + (row_cl[1] ? {1'b0, cols_eff} : 8'd0);
    addr_sum = row_off + {1'b0, col_cl};
  end

  always_comb begin
    disp_mask  = 3'd0;
    entry_mask = 2'd0;
    unique case (cmd.flag_select)
      FLG_DISPLAY:    disp_mask  = 3'b100;
      FLG_CURSOR:     disp_mask  = 3'b010;
      FLG_BLINK:      disp_mask  = 3'b001;
      FLG_INCREMENT:  entry_mask = 2'b10;
      FLG_AUTOSCROLL: entry_mask = 2'b01;
      default: begin
      end
    endcase
  end

  always_comb begin
    dec.has_bytes  = 1'b1;
    dec.desc.kind  = KIND_BYTE;
    dec.desc.value = 8'd0;
    dec.desc.rs    = 1'b0;
    dec.desc.wcode = WAIT_NONE;
    dec.desc.bl    = bl_cur;
    dec.disp_nxt   = disp_cur;
    dec.entry_nxt  = entry_cur;
    dec.bl_nxt     = bl_cur;
    unique case (cmd.action)
      ACT_INIT: begin
        dec.desc.kind = KIND_INIT;
        dec.disp_nxt  = DISP_RESET;
        dec.entry_nxt = ENTRY_RESET;
      end
      ACT_WRITE: begin
        dec.desc.value = cmd.char_code;
        dec.desc.rs    = 1'b1;
      end
      ACT_CLEAR: begin
        dec.desc.value = CMD_CLEAR;
        dec.desc.wcode = WAIT_CLEAR;
      end
      ACT_HOME: begin
        dec.desc.value = CMD_HOME;
        dec.desc.wcode = WAIT_CLEAR;
      end
      ACT_CURSOR: begin
        dec.desc.value = CMD_DDRAM_ADDR | addr_sum;
      end
      ACT_FLAG: begin
        if (disp_mask != 3'd0) begin
          dec.disp_nxt   = cmd.flag_on ? (disp_cur | disp_mask) : (disp_cur & ~disp_mask);
          dec.desc.value = CMD_DISPLAY | {5'd0, dec.disp_nxt};
        end else if (entry_mask != 2'd0) begin
          dec.entry_nxt  = cmd.flag_on ? (entry_cur | entry_mask) : (entry_cur & ~entry_mask);
          dec.desc.value = CMD_ENTRY | {6'd0, dec.entry_nxt};
        end else begin
          dec.has_bytes = 1'b0;
        end
      end
      ACT_SCROLL: begin
        dec.desc.value = cmd.direction ? CMD_SCROLL_R : CMD_SCROLL_L;
      end
      ACT_BACKLIGHT: begin
        dec.desc.kind = KIND_PIN;
        dec.desc.rs   = 1'b1;
        dec.desc.bl   = cmd.brightness != 8'd0;
        dec.bl_nxt    = cmd.brightness != 8'd0;
      end
      ACT_GLYPH: begin
        dec.desc.value = CMD_GLYPH_ADDR | {2'd0, cmd.glyph_slot, 3'd0};
      end
      default: begin
        dec.has_bytes = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/lcdser_gen.sv @@
// bus byte generator: one output word from the held command and its byte index
`default_nettype none

module lcdser_gen
  import lcdser_pkg::*;
(
  input  desc_t           desc,
  input  logic [IdxW-1:0] idx,
  input  logic [6:0]      device_address,
  input  logic [2:0]      line_count,
  output out_word_t       word
);

  init_entry_t ie;
  logic        is_addr;
  logic [3:0]  nib;
  logic        en;
  logic        ends;
  wait_code_t  wcode;

  always_comb begin
    ie      = init_entry(idx);
    is_addr = 1'b0;
    nib     = 4'h0;
    en      = 1'b0;
    ends    = 1'b0;
    wcode   = WAIT_NONE;
    unique case (desc.kind)
      KIND_INIT: begin
        is_addr = ie.is_addr;
        en      = ie.en;
        ends    = ie.ends;
        wcode   = ie.wcode;
        if (ie.fs_low) begin
          nib = (line_count > 3'd1) ? 4'h8 : 4'h0;
        end else begin
          nib = ie.nib;
        end
      end
      KIND_BYTE: begin
        is_addr = idx == IdxW'(0);
        nib     = (idx < IdxW'(3)) ? desc.value[7:4] : desc.value[3:0];
        en      = idx[0];
        ends    = idx == IdxW'(4);
        wcode   = ends ? desc.wcode : WAIT_NONE;
      end
      default: begin
        is_addr = idx == IdxW'(0);
        ends    = idx == IdxW'(1);
      end
    endcase
    word.bus_byte        = is_addr ? {device_address, 1'b0}
                                   : {nib, desc.bl, en, 1'b0, desc.rs & (desc.kind != KIND_INIT)};
    word.starts_transfer = is_addr;
    word.ends_transfer   = ends;
    word.wait_us         = wait_value(wcode);
    word.last_of_run     = idx == last_index(desc.kind);
  end

endmodule

`default_nettype wire
